// ===== rtl/slps_pkg.sv =====
package slps_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned PAT_W      = 4;
    localparam int unsigned MS_W       = 8;
    localparam int unsigned ELAPSED_W  = 14;
    localparam int unsigned INTERVAL_W = 12;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned LED_W      = 2;
    localparam int unsigned ROW_W      = 20;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE   = 2'd2;

    localparam logic [PAT_W-1:0] PAT_POWER_ON     = 4'd0;
    localparam logic [PAT_W-1:0] PAT_ONLINE       = 4'd1;
    localparam logic [PAT_W-1:0] PAT_SCAN         = 4'd2;
    localparam logic [PAT_W-1:0] PAT_TRANSMISSION = 4'd4;
    localparam logic [PAT_W-1:0] PAT_SUCCEEDED    = 4'd5;
    localparam logic [PAT_W-1:0] PAT_FAILED       = 4'd6;
    localparam logic [PAT_W-1:0] PAT_NO_ID        = 4'd7;
    localparam logic [PAT_W-1:0] PAT_STANDBY      = 4'd10;
    localparam logic [PAT_W-1:0] PAT_COUNT        = 4'd11;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PAT_W-1:0] status;
        logic [MS_W-1:0]  elapsed_ms;
    } t_in;

    typedef struct packed {
        logic             led_one;
        logic             led_two;
        logic             led_written;
        logic [PAT_W-1:0] shown_status;
        logic [PAT_W-1:0] pending_status;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic logic [INTERVAL_W-1:0] pat_interval(input logic [PAT_W-1:0] pat);
        logic [INTERVAL_W-1:0] v;
        unique case (pat)
            4'd0:    v = 12'd250;
            4'd1:    v = 12'd1000;
            4'd2:    v = 12'd100;
            4'd3:    v = 12'd250;
            4'd4:    v = 12'd200;
            4'd5:    v = 12'd1000;
            4'd6:    v = 12'd1000;
            4'd7:    v = 12'd500;
            4'd8:    v = 12'd200;
            4'd9:    v = 12'd3000;
            4'd10:   v = 12'd250;
            default: v = 12'd250;
        endcase
        return v;
    endfunction

    function automatic logic [ELAPSED_W-1:0] pat_cycle(input logic [PAT_W-1:0] pat);
        logic [ELAPSED_W-1:0] v;
        unique case (pat)
            4'd2:    v = 14'd800;
            4'd8:    v = 14'd4000;
            4'd9:    v = 14'd12000;
            4'd10:   v = 14'd2000;
            default: v = 14'd1000;
        endcase
        return v;
    endfunction

    function automatic logic [STEP_W-1:0] pat_words(input logic [PAT_W-1:0] pat);
        logic [STEP_W-1:0] v;
        unique case (pat)
            4'd1, 4'd5, 4'd6: v = 4'd1;
            4'd2, 4'd10:      v = 4'd8;
            4'd8:             v = 4'd10;
            4'd9:             v = 4'd4;
            default:          v = 4'd2;
        endcase
        return v;
    endfunction

    function automatic logic [LED_W-1:0] pat_word(input logic [PAT_W-1:0] pat,
                                                  input logic [STEP_W-1:0] idx);
        logic [ROW_W-1:0] row;
        unique case (pat)
            4'd0:    row = 20'h00003;
            4'd2:    row = 20'h00033;
            4'd3:    row = 20'h00002;
            4'd6:    row = 20'h00002;
            4'd7:    row = 20'h00003;
            4'd8:    row = 20'h00222;
            4'd9:    row = 20'h00021;
            default: row = 20'h00001;
        endcase
        if (idx >= 4'd10) begin
            return '0;
        end
        return row[{idx, 1'b0} +: LED_W];
    endfunction

endpackage

// ===== rtl/status_led_pattern_sequencer_core.sv =====
// Status LED pattern sequencer.
// Input channel (i_in_valid / o_in_stall) carries tick, request-status and
// force-status items; a transfer happens when valid is high and stall low.
// Output channel (o_out_valid / i_out_stall) returns one result per item:
// LED levels, whether a new word was shown, the playing and pending patterns.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the single
// device_id_missing bit; it is always ready.
// A tick passes from transfer to result through a load step, a bit-per-cycle
// restoring remainder of the 14-bit elapsed count by the pattern interval in
// one shared compare-subtract unit, and a commit step. Request, force and
// unknown commands go from the load step straight to commit. Items are
// handled one at a time; the next item may be transferred as soon as the
// previous result sits in the output register.
// If the receiver stalls, the result holds in the output register; a
// finished item then waits in its commit cycle until the register frees.
// Reset: power-on pattern, count, step and LEDs zero, no result pending.
module status_led_pattern_sequencer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  slps_pkg::t_in i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output slps_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    localparam logic [slps_pkg::STEP_W-1:0] CNT_TOP = 4'(slps_pkg::ELAPSED_W - 1);

    slps_pkg::t_state r_state, n_state;

    logic                            r_id_missing;
    logic [slps_pkg::PAT_W-1:0]      r_cur, n_cur;
    logic [slps_pkg::PAT_W-1:0]      r_pend, n_pend;
    logic [slps_pkg::ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [slps_pkg::STEP_W-1:0]     r_step, n_step;
    logic [slps_pkg::LED_W-1:0]      r_led, n_led;
    logic                            r_out_valid, n_out_valid;
    slps_pkg::t_out                  r_out, n_out;

    logic [slps_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [slps_pkg::PAT_W-1:0]      r_req, n_req;
    logic [slps_pkg::ELAPSED_W-1:0]  r_sum, n_sum;
    logic [slps_pkg::INTERVAL_W-1:0] r_rem, n_rem;
    logic [slps_pkg::STEP_W-1:0]     r_cnt, n_cnt;

    logic [slps_pkg::INTERVAL_W-1:0] interval;
    logic [slps_pkg::INTERVAL_W:0]   trial;
    logic [slps_pkg::ELAPSED_W:0]    sum_wide;
    logic [slps_pkg::STEP_W-1:0]     idx;
    logic                            in_xfer;
    logic                            out_free;
    logic                            written;

    assign o_in_stall  = (r_state != slps_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign interval = slps_pkg::pat_interval(r_cur);
    assign trial    = {r_rem, r_sum[r_cnt]};
    assign sum_wide = {1'b0, r_elapsed} + {{(slps_pkg::ELAPSED_W - slps_pkg::MS_W + 1){1'b0}},
                                           i_in.elapsed_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slps_pkg::ST_IDLE;
            r_id_missing <= 1'b0;
            r_cur        <= slps_pkg::PAT_POWER_ON;
            r_pend       <= slps_pkg::PAT_POWER_ON;
            r_elapsed    <= '0;
            r_step       <= '0;
            r_led        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_pend      <= n_pend;
            r_elapsed   <= n_elapsed;
            r_step      <= n_step;
            r_led       <= n_led;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_id_missing <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_cmd <= n_cmd;
        r_req <= n_req;
        r_sum <= n_sum;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_pend      = r_pend;
        n_elapsed   = r_elapsed;
        n_step      = r_step;
        n_led       = r_led;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_cmd       = r_cmd;
        n_req       = r_req;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        idx         = '0;
        written     = 1'b0;

        unique case (r_state)
            slps_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_cmd = i_in.command;
                    n_req = i_in.status;
                    n_sum = sum_wide[slps_pkg::ELAPSED_W-1:0];
                    n_rem = '0;
                    n_cnt = CNT_TOP;
                    if (i_in.command == slps_pkg::CMD_TICK) begin
                        n_state = slps_pkg::ST_DIV;
                    end else begin
                        n_state = slps_pkg::ST_DONE;
                    end
                end
            end
            slps_pkg::ST_DIV: begin
                if (trial >= {1'b0, interval}) begin
                    n_rem = slps_pkg::INTERVAL_W'(trial - {1'b0, interval});
                end else begin
                    n_rem = trial[slps_pkg::INTERVAL_W-1:0];
                end
                if (r_cnt == '0) begin
                    n_state = slps_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            slps_pkg::ST_DONE: begin
                if (out_free) begin
                    case (r_cmd)
                        slps_pkg::CMD_TICK: begin
                            n_elapsed = r_sum;
                            if (r_rem == '0) begin
                                idx = (r_step >= slps_pkg::pat_words(r_cur)) ? '0 : r_step;
                                n_led   = slps_pkg::pat_word(r_cur, idx);
                                n_step  = idx + 1'b1;
                                written = 1'b1;
                            end
                            if (r_sum >= slps_pkg::pat_cycle(r_cur)) begin
                                n_elapsed = '0;
                                n_step    = '0;
                                if (r_pend != slps_pkg::PAT_STANDBY) begin
                                    n_cur = r_pend;
                                    if (r_pend != slps_pkg::PAT_TRANSMISSION &&
                                        r_pend != slps_pkg::PAT_SUCCEEDED &&
                                        r_pend != slps_pkg::PAT_FAILED &&
                                        r_pend != slps_pkg::PAT_SCAN) begin
                                        n_pend = slps_pkg::PAT_STANDBY;
                                    end
                                end
                            end
                        end
                        slps_pkg::CMD_REQUEST: begin
                            if (r_req < slps_pkg::PAT_COUNT) begin
                                if (r_id_missing && r_req != slps_pkg::PAT_POWER_ON) begin
                                    n_pend = slps_pkg::PAT_NO_ID;
                                end else if (r_pend == slps_pkg::PAT_STANDBY) begin
                                    n_pend = r_req;
                                end else if (r_req != slps_pkg::PAT_ONLINE) begin
                                    n_pend = r_req;
                                end
                            end
                        end
                        slps_pkg::CMD_FORCE: begin
                            if (r_req < slps_pkg::PAT_COUNT) begin
                                n_cur     = r_req;
                                n_elapsed = '0;
                                n_step    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.led_one        = n_led[0];
                    n_out.led_two        = n_led[1];
                    n_out.led_written    = written;
                    n_out.shown_status   = n_cur;
                    n_out.pending_status = n_pend;
                    n_out_valid          = 1'b1;
                    n_state              = slps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slps_pkg::ST_IDLE;
            end
        endcase
    end

    a_stall_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur < slps_pkg::PAT_COUNT)
        else $error("current pattern out of range");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend < slps_pkg::PAT_COUNT)
        else $error("pending pattern out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slps_pkg::ST_DIV) |-> (r_rem < interval))
        else $error("remainder not below interval");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == slps_pkg::ST_DONE))
        else $error("result loaded outside commit");

endmodule

// ===== tb/status_led_pattern_sequencer_checker.sv =====
module status_led_pattern_sequencer_checker
    import slps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out,
    input  logic i_cfg_valid,
    input  logic i_cfg_ready,
    input  logic i_cfg_data,
    output int   o_errors,
    output int   o_outstanding,
    output int   o_checked
);

    logic                 no_id;
    logic [PAT_W-1:0]     cur_pat;
    logic [PAT_W-1:0]     next_pat;
    logic [ELAPSED_W-1:0] elapsed;
    logic [STEP_W-1:0]    step_idx;
    logic [LED_W-1:0]     leds;
    t_out                 status_due[$];
    int                   fail_count = 0;
    int                   checked = 0;

    function automatic int step_ms(input logic [PAT_W-1:0] pat);
        case (pat)
            4'd1, 4'd5, 4'd6: return 1000;
            4'd2:             return 100;
            4'd4, 4'd8:       return 200;
            4'd7:             return 500;
            4'd9:             return 3000;
            default:          return 250;
        endcase
    endfunction

    function automatic int cycle_ms(input logic [PAT_W-1:0] pat);
        case (pat)
            4'd2:    return 800;
            4'd8:    return 4000;
            4'd9:    return 12000;
            4'd10:   return 2000;
            default: return 1000;
        endcase
    endfunction

    function automatic int word_count(input logic [PAT_W-1:0] pat);
        case (pat)
            4'd1, 4'd5, 4'd6: return 1;
            4'd2, 4'd10:      return 8;
            4'd8:             return 10;
            4'd9:             return 4;
            default:          return 2;
        endcase
    endfunction

    function automatic logic [LED_W-1:0] word_at(input logic [PAT_W-1:0] pat,
                                                 input logic [STEP_W-1:0] idx);
        logic [0:9][LED_W-1:0] row;
        case (pat)
            4'd0, 4'd7: row = {2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
            4'd2:       row = {2'd3, 2'd0, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
            4'd3, 4'd6: row = {2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
            4'd8:       row = {2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
            4'd9:       row = {2'd1, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
            default:    row = {2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
        endcase
        return row[idx % 10];
    endfunction

    task automatic advance_pattern(input t_in item, output t_out res);
        logic shown;
        shown = 1'b0;
        case (item.command)
            CMD_TICK: begin
                elapsed = elapsed + ELAPSED_W'(item.elapsed_ms);
                if ((int'(elapsed) % step_ms(cur_pat)) == 0) begin
                    if (int'(step_idx) >= word_count(cur_pat)) begin
                        step_idx = '0;
                    end
                    leds     = word_at(cur_pat, step_idx);
                    step_idx = step_idx + 1'b1;
                    shown    = 1'b1;
                end
                if (int'(elapsed) >= cycle_ms(cur_pat)) begin
                    elapsed  = '0;
                    step_idx = '0;
                    if (next_pat != PAT_STANDBY) begin
                        cur_pat = next_pat;
                        if (next_pat != PAT_TRANSMISSION && next_pat != PAT_SUCCEEDED &&
                            next_pat != PAT_FAILED && next_pat != PAT_SCAN) begin
                            next_pat = PAT_STANDBY;
                        end
                    end
                end
            end
            CMD_REQUEST: begin
                if (item.status < PAT_COUNT) begin
                    if (no_id && item.status != PAT_POWER_ON) begin
                        next_pat = PAT_NO_ID;
                    end else if (next_pat == PAT_STANDBY) begin
                        next_pat = item.status;
                    end else if (item.status != PAT_ONLINE) begin
                        next_pat = item.status;
                    end
                end
            end
            CMD_FORCE: begin
                if (item.status < PAT_COUNT) begin
                    cur_pat  = item.status;
                    elapsed  = '0;
                    step_idx = '0;
                end
            end
            default: begin
            end
        endcase
        res.led_one        = leds[0];
        res.led_two        = leds[1];
        res.led_written    = shown;
        res.shown_status   = cur_pat;
        res.pending_status = next_pat;
    endtask

    task automatic check_field(input string name, input logic [PAT_W-1:0] want,
                               input logic [PAT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            no_id    = 1'b0;
            cur_pat  = PAT_POWER_ON;
            next_pat = PAT_POWER_ON;
            elapsed  = '0;
            step_idx = '0;
            leds     = '0;
            status_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                no_id = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $error("result transfer with nothing expected: %h", i_out);
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    check_field("led_one", PAT_W'(want.led_one), PAT_W'(i_out.led_one));
                    check_field("led_two", PAT_W'(want.led_two), PAT_W'(i_out.led_two));
                    check_field("led_written", PAT_W'(want.led_written),
                                PAT_W'(i_out.led_written));
                    check_field("shown_status", want.shown_status, i_out.shown_status);
                    check_field("pending_status", want.pending_status, i_out.pending_status);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_pattern(i_in, want);
                status_due.push_back(want);
            end
        end
        o_errors      <= fail_count;
        o_outstanding <= status_due.size();
        o_checked     <= checked;
    end

endmodule

// ===== tb/tb_status_led_pattern_sequencer_core.sv =====
module tb_status_led_pattern_sequencer_core;
    import slps_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 40;

    localparam int STALL_NONE     = 0;
    localparam int STALL_SPARSE   = 1;
    localparam int STALL_PERIODIC = 2;
    localparam int STALL_HEAVY    = 3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_item   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data  = 1'b0;

    int errors;
    int outstanding;
    int checked;
    int hold_ask   = 0;
    int burst_left = 0;
    int live       = 0;
    int n_tick     = 0;
    int n_req      = 0;
    int n_force    = 0;
    int n_other    = 0;
    int n_cfg      = 0;

    always #5 clk = ~clk;

    status_led_pattern_sequencer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    status_led_pattern_sequencer_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    function automatic t_in mk_item(input logic [CMD_W-1:0] cmd, input logic [PAT_W-1:0] st,
                                    input logic [MS_W-1:0] ms);
        t_in it;
        it.command    = cmd;
        it.status     = st;
        it.elapsed_ms = ms;
        return it;
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd50;
            2:       return 8'd100;
            3:       return 8'd125;
            4:       return 8'd200;
            5, 6:    return 8'd250;
            default: return MS_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PAT_W-1:0] any_pattern();
        return PAT_W'($urandom_range(0, PAT_COUNT - 1));
    endfunction

    task automatic send(input t_in it);
        int gap;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 24);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        burst_left--;
        case (it.command)
            CMD_TICK:    n_tick++;
            CMD_REQUEST: n_req++;
            CMD_FORCE:   n_force++;
            default:     n_other++;
        endcase
        if (it.command == CMD_TICK || (it.command != CMD_NONE && it.status < PAT_COUNT)) begin
            live++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_cfg(input logic value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin : receiver
        int mode;
        int left;
        int hold_seen;
        int hold_left;
        int cyc;
        mode      = STALL_NONE;
        left      = 0;
        hold_seen = 0;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = LONG_HOLD;
            end
            if (left == 0) begin
                mode = $urandom_range(STALL_NONE, STALL_HEAVY);
                left = $urandom_range(50, 300);
            end
            left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_SPARSE:   out_stall <= ($urandom_range(0, 2) == 0);
                    STALL_PERIODIC: out_stall <= ((cyc % 7) < 3);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    default:        out_stall <= 1'b0;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int  kind;
        int  runs;
        int  next_cfg;
        bit  held;
        bit  paused;
        logic [CMD_W-1:0] op;
        held     = 1'b0;
        paused   = 1'b0;
        next_cfg = 150;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        write_cfg(1'b0);
        send(mk_item(CMD_TICK, PAT_POWER_ON, 8'd0));
        send(mk_item(CMD_TICK, 4'd15, 8'd255));
        send(mk_item(CMD_TICK, PAT_POWER_ON, 8'd245));
        send(mk_item(CMD_REQUEST, PAT_ONLINE, 8'd0));
        send(mk_item(CMD_REQUEST, PAT_SCAN, 8'd0));
        send(mk_item(CMD_TICK, PAT_POWER_ON, 8'd250));
        send(mk_item(CMD_TICK, PAT_POWER_ON, 8'd250));
        send(mk_item(CMD_REQUEST, 4'd15, 8'd255));
        send(mk_item(CMD_FORCE, 4'd11, 8'd0));
        send(mk_item(CMD_NONE, 4'd15, 8'd255));
        send(mk_item(CMD_NONE, PAT_POWER_ON, 8'd0));
        send(mk_item(CMD_FORCE, PAT_STANDBY, 8'd0));
        send(mk_item(CMD_REQUEST, PAT_POWER_ON, 8'd0));
        send(mk_item(CMD_FORCE, 4'd9, 8'd0));
        send(mk_item(CMD_TICK, PAT_POWER_ON, 8'd0));
        write_cfg(1'b1);
        send(mk_item(CMD_REQUEST, PAT_ONLINE, 8'd0));
        send(mk_item(CMD_REQUEST, PAT_POWER_ON, 8'd0));
        send(mk_item(CMD_REQUEST, PAT_STANDBY, 8'd0));
        send(mk_item(CMD_FORCE, PAT_POWER_ON, 8'd0));
        repeat (4) send(mk_item(CMD_TICK, PAT_POWER_ON, 8'd250));
        write_cfg(1'b0);
        send(mk_item(CMD_REQUEST, PAT_ONLINE, 8'd0));
        send(mk_item(CMD_TICK, PAT_STANDBY, 8'd1));

        live = 0;
        while (live < RANDOM_ITEMS) begin
            if (!held && live >= 250) begin
                held = 1'b1;
                hold_ask++;
            end
            if (!paused && live >= 500) begin
                paused = 1'b1;
                wait_drained();
            end
            if (live >= next_cfg) begin
                write_cfg(1'($urandom_range(0, 1)));
                next_cfg += $urandom_range(100, 250);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                if ($urandom_range(0, 3) != 0) begin
                    op = ($urandom_range(0, 2) == 0) ? CMD_FORCE : CMD_REQUEST;
                    send(mk_item(op, any_pattern(), MS_W'($urandom)));
                end
                runs = ($urandom_range(0, 7) == 0) ? $urandom_range(48, 70)
                                                   : $urandom_range(3, 30);
                repeat (runs) send(mk_item(CMD_TICK, PAT_W'($urandom), pick_ms()));
            end else if (kind <= 8) begin
                send(mk_item(CMD_W'($urandom), PAT_W'($urandom), MS_W'($urandom)));
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    send(mk_item(CMD_NONE, PAT_W'($urandom), MS_W'($urandom)));
                end else begin
                    op = ($urandom_range(0, 1) == 0) ? CMD_FORCE : CMD_REQUEST;
                    send(mk_item(op, PAT_W'($urandom_range(PAT_COUNT, 15)), MS_W'($urandom)));
                end
                repeat ($urandom_range(1, 4)) send(mk_item(CMD_TICK, PAT_W'($urandom), pick_ms()));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d ticks, %0d requests, %0d forces, %0d idle commands",
                 n_tick, n_req, n_force, n_other);
        $display("with %0d register writes; %0d results compared, %0d mismatches.",
                 n_cfg, checked, errors);
        if (errors == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/slps_pkg.sv
rtl/status_led_pattern_sequencer_core.sv
tb/status_led_pattern_sequencer_checker.sv
tb/tb_status_led_pattern_sequencer_core.sv
